>>> sv/vsbc_pkg.sv
// Package for the video shot boundary classifier.
// Holds the shared widths, the result and push types and the register indexes.
// No dependencies.
`default_nettype none

package vsbc_pkg;

  // Width of the internal frame counter and distances.
  localparam int unsigned FRAME_IDX_W = 20;
  // Width of the frame_number field in each result.
  localparam int unsigned FRAME_NUM_W = 20;
  // Compare width for distance against the gap register.
  localparam int unsigned GAP_W = 10;
  localparam int unsigned DIST_CMP_W = (FRAME_IDX_W > GAP_W) ? FRAME_IDX_W : GAP_W;

  localparam int unsigned DIFF_W = 16;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Result queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // Output stream payload width: frame_number, new_shot, was_uncertain, padded to bytes.
  localparam int unsigned OUT_FIELDS_W = FRAME_NUM_W + 2;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_TDATA_W = ((DIFF_W + 7) / 8) * 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_THRESHOLD = 2'd0,
    CFG_LOWER_THRESHOLD = 2'd1,
    CFG_MIN_SHOT_GAP    = 2'd2
  } cfg_idx_e;

  // One decision leaving the block.
  typedef struct packed {
    logic [FRAME_NUM_W-1:0] frame_number;
    logic                   new_shot;
    logic                   was_uncertain;
    logic                   run_end;
  } result_t;

  // What the front hands to the queue on one accepted beat.
  typedef struct packed {
    logic [1:0] count;  // zero, one or two results
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

>>> sv/video_shot_boundary_classifier.sv
// Shot boundary classifier, top level: connects front, result queue and back.
// Depends on vsbc_pkg, vsbc_front, vsbc_queue and vsbc_back.
//
// Each input beat carries one frame's complexity difference (Q8.8) with tlast
// marking the last frame of a sequence. Every beat yields zero, one or two
// result beats; tlast on the output marks the last result caused by one input.
// An uncertain frame is held until the next uncertain frame or the end of the
// sequence decides it, so results can leave out of frame order. The block
// takes one input beat per clock cycle; the output register drains one result
// per cycle while the sink is ready, so a run of two-result beats is paced by that drain
// through the four-entry result queue, and input is held off while fewer than two
// entries are free. Results pass through the queue and then the output register.
`default_nettype none

module video_shot_boundary_classifier
  import vsbc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] difference
  input  wire logic                   s_axis_tlast,   // final_frame
  // Output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [19:0] frame_number, [20] new_shot,
                                                      // [21] was_uncertain, rest zero
  output logic                        m_axis_tlast    // run_end
);

  push_t   push;
  logic    q_space, q_not_empty, q_pop;
  result_t q_head, out_res;

  vsbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_diff_i  (s_axis_tdata[DIFF_W-1:0]),
    .in_final_i (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_space_i  (q_space),
    .push_o     (push)
  );

  vsbc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (q_space),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .head_o      (q_head)
  );

  vsbc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (out_res)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = OUT_TDATA_W'({out_res.was_uncertain, out_res.new_shot,
                                      out_res.frame_number});
  assign m_axis_tlast = out_res.run_end;

endmodule

`default_nettype wire

>>> sv/vsbc_front.sv
// Front end of the classifier: configuration registers, sequence state and
// the per-frame decision logic. Depends on vsbc_pkg.
`default_nettype none

module vsbc_front
  import vsbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input beat
  input  wire logic                  in_valid_i,
  input  wire logic [DIFF_W-1:0]     in_diff_i,
  input  wire logic                  in_final_i,
  output logic                       in_ready_o,
  // Queue side
  input  wire logic                  q_space_i,
  output push_t                      push_o
);

  logic [THRESH_W-1:0]    upper_q, lower_q;
  logic [GAP_W-1:0]       gap_q;
  logic [FRAME_IDX_W-1:0] frame_q, frame_d;
  logic [FRAME_IDX_W-1:0] last_firm_q, last_firm_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [FRAME_IDX_W-1:0] pend_frame_q, pend_frame_d;
  logic [FRAME_IDX_W-1:0] pend_dist_q, pend_dist_d;

  logic                   accept;
  logic                   is_first, is_second, above, below, firm, firm_shot;
  logic [FRAME_IDX_W-1:0] cur_dist;
  logic                   gap_shot;
  result_t                cur_res, pend_res;
  push_t                  push;

  // Configuration registers are to be written while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '1;
      lower_q <= '0;
      gap_q   <= GAP_W'(30);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_UPPER_THRESHOLD: upper_q <= THRESH_W'(cfg_data_i);
        CFG_LOWER_THRESHOLD: lower_q <= THRESH_W'(cfg_data_i);
        CFG_MIN_SHOT_GAP:    gap_q   <= GAP_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign in_ready_o = q_space_i;
  assign accept     = in_valid_i && q_space_i;

  // Classification of the current frame.
  assign is_first  = (frame_q == '0);
  assign is_second = (frame_q == FRAME_IDX_W'(1));
  assign above     = (in_diff_i > upper_q);
  assign below     = (in_diff_i < lower_q);
  assign firm      = is_first || is_second || above || below;
  assign firm_shot = is_first || (!is_second && above);
  assign cur_dist  = frame_q - last_firm_q;
  assign gap_shot  = (DIST_CMP_W'(pend_dist_q) > DIST_CMP_W'(gap_q)) &&
                     (DIST_CMP_W'(cur_dist) > DIST_CMP_W'(gap_q));

  // Build the results and the next sequence state.
  always_comb begin
    cur_res.frame_number  = FRAME_NUM_W'(frame_q);
    cur_res.new_shot      = firm ? firm_shot : 1'b0;
    cur_res.was_uncertain = !firm;
    cur_res.run_end       = 1'b1;

    pend_res.frame_number  = FRAME_NUM_W'(pend_frame_q);
    pend_res.new_shot      = firm ? 1'b0 : gap_shot;
    pend_res.was_uncertain = 1'b1;
    pend_res.run_end       = 1'b0;

    push.count  = 2'd0;
    push.first  = cur_res;
    push.second = cur_res;

    frame_d      = frame_q + FRAME_IDX_W'(1);
    last_firm_d  = last_firm_q;
    pend_valid_d = pend_valid_q;
    pend_frame_d = pend_frame_q;
    pend_dist_d  = pend_dist_q;

    if (firm) begin
      // A firm frame always yields its own result; a held frame leaves only at the end.
      if (firm_shot) begin
        last_firm_d = frame_q;
      end
      if (in_final_i && pend_valid_q) begin
        push.count  = 2'd2;
        push.first  = pend_res;
      end else begin
        push.count = 2'd1;
      end
    end else begin
      // Uncertain frame: settle the held one, then hold or flush this one.
      if (pend_valid_q && in_final_i) begin
        push.count = 2'd2;
        push.first = pend_res;
      end else if (pend_valid_q) begin
        push.count = 2'd1;
        push.first = pend_res;
        push.first.run_end = 1'b1;
      end else if (in_final_i) begin
        push.count = 2'd1;
      end
      pend_valid_d = !in_final_i;
      pend_frame_d = frame_q;
      pend_dist_d  = cur_dist;
    end

    // End of sequence returns to frame zero with nothing held.
    if (in_final_i) begin
      frame_d      = '0;
      last_firm_d  = '0;
      pend_valid_d = 1'b0;
      pend_frame_d = '0;
      pend_dist_d  = '0;
    end

    if (!accept) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q      <= '0;
      last_firm_q  <= '0;
      pend_valid_q <= 1'b0;
      pend_frame_q <= '0;
      pend_dist_q  <= '0;
    end else if (accept) begin
      frame_q      <= frame_d;
      last_firm_q  <= last_firm_d;
      pend_valid_q <= pend_valid_d;
      pend_frame_q <= pend_frame_d;
      pend_dist_q  <= pend_dist_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/vsbc_queue.sv
// Short result queue between front and back: takes up to two results a cycle
// and hands out one. Depends on vsbc_pkg.
`default_nettype none

module vsbc_queue
  import vsbc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire push_t push_i,
  output logic      space_o,
  input  wire logic pop_i,
  output logic      not_empty_o,
  output result_t   head_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_next;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign wr_ptr_next = wr_ptr_q + QPTR_W'(1);
  assign do_pop      = pop_i && (count_q != '0);
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  // Room for a full two-result beat, ignoring a pop in the same cycle.
  assign space_o     = (count_q <= QCNT_W'(QDEPTH - 2));

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_next] <= push_i.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_i.count);
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i.count) - QCNT_W'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> sv/vsbc_back.sv
// Back end of the classifier: output register that drains the result queue
// onto the master stream. Depends on vsbc_pkg.
`default_nettype none

module vsbc_back
  import vsbc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     q_not_empty_i,
  input  wire result_t  q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output result_t       out_res_o
);

  logic    valid_q;
  result_t res_q;
  logic    load;

  // Refill whenever the register is empty or its beat is being taken.
  assign load    = q_not_empty_i && (!valid_q || out_ready_i);
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= q_head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

>>> tb/tb_video_shot_boundary_classifier.sv
// Self-checking testbench for the video shot boundary classifier.
// Streams difference beats with random idling on both sides and checks each result
// beat against a cycle-free prediction of the shot decisions. Depends on vsbc_pkg.
`default_nettype none

module tb_video_shot_boundary_classifier;
  timeunit 1ns;
  timeprecision 1ps;
  import vsbc_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata;   // [15:0] difference
  logic                    s_axis_tlast;   // final_frame
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // [19:0] frame_number, [20] new_shot,
                                           // [21] was_uncertain, rest zero
  logic                    m_axis_tlast;   // run_end

  video_shot_boundary_classifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Tracks the classifier state and holds the decisions still to leave the block.
  class shot_scoreboard;
    logic [THRESH_W-1:0]    upper_thr;
    logic [THRESH_W-1:0]    lower_thr;
    logic [GAP_W-1:0]       min_gap;
    logic [FRAME_IDX_W-1:0] next_frame;
    logic [FRAME_IDX_W-1:0] firm_frame;
    logic [FRAME_IDX_W-1:0] held_frame;
    logic [FRAME_IDX_W-1:0] held_dist;
    bit                     held;
    result_t                decisions_q[$];
    int unsigned            n_frames, n_runs, n_results, n_gap_rule, n_shots, n_errors;

    function new();
      upper_thr = '1;
      lower_thr = '0;
      min_gap   = GAP_W'(30);
      n_frames = 0; n_runs = 0; n_results = 0;
      n_gap_rule = 0; n_shots = 0; n_errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      next_frame = '0;
      firm_frame = '0;
      held_frame = '0;
      held_dist  = '0;
      held       = 1'b0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_UPPER_THRESHOLD: upper_thr = value[THRESH_W-1:0];
        CFG_LOWER_THRESHOLD: lower_thr = value[THRESH_W-1:0];
        CFG_MIN_SHOT_GAP:    min_gap   = value[GAP_W-1:0];
        default: ;
      endcase
    endfunction

    function result_t decision(logic [FRAME_IDX_W-1:0] frame, bit shot, bit gap_rule);
      result_t r;
      r.frame_number  = frame[FRAME_NUM_W-1:0];
      r.new_shot      = shot;
      r.was_uncertain = gap_rule;
      r.run_end       = 1'b0;
      return r;
    endfunction

    // Works out the decisions caused by one accepted difference beat.
    function void note_frame(logic [DIFF_W-1:0] diff, logic last);
      logic [FRAME_IDX_W-1:0] frame;
      logic [FRAME_IDX_W-1:0] cur_dist;
      bit                     shot;
      result_t                outs[$];
      frame = next_frame;
      n_frames++;
      if (frame < 2 || diff > upper_thr || diff < lower_thr) begin
        // Decided by position or by the thresholds; a held frame stays held
        // unless the run ends here.
        if (frame == 0) shot = 1'b1;
        else if (frame == 1) shot = 1'b0;
        else shot = diff > upper_thr;
        if (shot) firm_frame = frame;
        if (last && held) begin
          outs.push_back(decision(held_frame, 1'b0, 1'b1));
          held = 1'b0;
        end
        outs.push_back(decision(frame, shot, 1'b0));
      end else begin
        // Uncertain: settles the held frame and takes its place, or is flushed when the run ends.
        cur_dist = frame - firm_frame;
        if (held) outs.push_back(decision(held_frame,
                                          held_dist > min_gap && cur_dist > min_gap, 1'b1));
        if (last) begin
          outs.push_back(decision(frame, 1'b0, 1'b1));
          held = 1'b0;
        end else begin
          held       = 1'b1;
          held_frame = frame;
          held_dist  = cur_dist;
        end
      end
      if (outs.size() > 0) outs[outs.size()-1].run_end = 1'b1;
      foreach (outs[i]) decisions_q.push_back(outs[i]);
      if (last) begin
        n_runs++;
        clear_run();
      end else begin
        next_frame = frame + 1'b1;
      end
    endfunction

    // Compares one result beat with the oldest decision still waiting.
    function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
      result_t want;
      result_t got;
      got.frame_number  = data[FRAME_NUM_W-1:0];
      got.new_shot      = data[FRAME_NUM_W];
      got.was_uncertain = data[FRAME_NUM_W+1];
      got.run_end       = last;
      if (decisions_q.size() == 0) begin
        n_errors++;
        $display("%0t: result beat with nothing expected: frame %0d shot %b uncertain %b end %b",
                 $time, got.frame_number, got.new_shot, got.was_uncertain, got.run_end);
        return;
      end
      want = decisions_q.pop_front();
      n_results++;
      if (want.was_uncertain) n_gap_rule++;
      if (want.new_shot) n_shots++;
      if (got !== want || data[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0) begin
        n_errors++;
        $display("%0t: expected frame %0d shot %b uncertain %b end %b pad 0",
                 $time, want.frame_number, want.new_shot, want.was_uncertain, want.run_end);
        $display("%0t:   actual frame %0d shot %b uncertain %b end %b pad %0h",
                 $time, got.frame_number, got.new_shot, got.was_uncertain, got.run_end,
                 data[OUT_TDATA_W-1:OUT_FIELDS_W]);
      end
    endfunction

    function int unsigned outstanding();
      return decisions_q.size();
    endfunction
  endclass

  shot_scoreboard sb;
  int             src_quiet = 0;
  int             snk_quiet = 0;

  // Idle length for either side: mostly none or short, a few long, and now and
  // then a quiet stretch with no idling at all.
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet = $urandom_range(20, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Difference value aimed at the bands set by the current thresholds.
  function automatic logic [DIFF_W-1:0] pick_diff(bit avoid_firm);
    int          r;
    int unsigned hi;
    int unsigned lo;
    hi = sb.upper_thr;
    lo = sb.lower_thr;
    r  = $urandom_range(0, 99);
    if (avoid_firm) r = (r < 90) ? 0 : 55;
    if (r < 40 && lo <= hi) return DIFF_W'($urandom_range(lo, hi));
    if (r < 52 && hi < 65535) return DIFF_W'($urandom_range(hi + 1, 65535));
    if (r < 64 && lo > 0) return DIFF_W'($urandom_range(0, lo - 1));
    if (r < 72) return r[0] ? DIFF_W'(hi) : DIFF_W'(lo);
    return DIFF_W'($urandom());
  endfunction

  function automatic int run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 20) return $urandom_range(2, 3);
    if (r < 85) return $urandom_range(4, 40);
    return $urandom_range(41, 120);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sends one difference beat; tvalid stays high after acceptance so that
  // back-to-back beats need no gap.
  task automatic send_frame(input logic [DIFF_W-1:0] diff, input logic last);
    int gap;
    gap = idle_len(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(diff);
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_frame(diff, last);
  endtask

  task automatic play_run(input logic [DIFF_W-1:0] vals[$]);
    foreach (vals[i]) send_frame(vals[i], i == vals.size() - 1);
  endtask

  task automatic random_run(input int len, input bit avoid_firm);
    for (int i = 0; i < len; i++) send_frame(pick_diff(avoid_firm), i == len - 1);
  endtask

  // Drops tvalid and waits until every decision has left, plus the pipeline depth.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [THRESH_W-1:0] upper, input logic [THRESH_W-1:0] lower,
                              input logic [GAP_W-1:0] gap);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_UPPER_THRESHOLD;
    cfg_data_i <= CFG_DATA_W'(upper);
    sb.set_reg(CFG_UPPER_THRESHOLD, CFG_DATA_W'(upper));
    @(posedge clk_i);
    cfg_idx_i  <= CFG_LOWER_THRESHOLD;
    cfg_data_i <= CFG_DATA_W'(lower);
    sb.set_reg(CFG_LOWER_THRESHOLD, CFG_DATA_W'(lower));
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MIN_SHOT_GAP;
    cfg_data_i <= CFG_DATA_W'(gap);
    sb.set_reg(CFG_MIN_SHOT_GAP, CFG_DATA_W'(gap));
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Result side: checks each accepted beat and stalls tready at random.
  initial begin
    int stall_left;
    int n;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        n = idle_len(snk_quiet);
        if (n > 0) begin
          stall_left = n - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [DIFF_W-1:0]   seq_q[$];
    logic [THRESH_W-1:0] up_tab[6];
    logic [THRESH_W-1:0] lo_tab[6];
    logic [GAP_W-1:0]    gap_tab[6];
    int unsigned         random_beats;
    int                  phase_beats;
    int                  phase_goal;
    int                  len;
    int                  p;
    int unsigned         up, lo, gapv;

    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_UPPER_THRESHOLD;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds leave every frame from 2 on uncertain; none passes the gap.
    seq_q = '{16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000};
    play_run(seq_q);
    settle();

    program_regs(16'h8000, 16'h4000, 10'd2);
    // Firm shot, no shot, values equal to each threshold, a firm frame while one
    // is held (out of order), gap-rule shots, and a final uncertain frame.
    seq_q = '{16'h0000, 16'hFFFF, 16'h8001, 16'h3FFF, 16'h4000, 16'h8000, 16'hFFFF,
              16'h0000, 16'h0000, 16'h6000, 16'h5000, 16'h7000};
    play_run(seq_q);
    // A run of one frame.
    seq_q = '{16'h9000};
    play_run(seq_q);
    // A firm final frame flushes the held one first.
    seq_q = '{16'h1000, 16'h1000, 16'h6000, 16'h0100};
    play_run(seq_q);
    settle();

    // Fixed settings first (extremes and crossed thresholds), then one long run
    // so distances pass a wide gap, then random settings.
    up_tab  = '{16'h8000, 16'h0000, 16'hFFFF, 16'h3000, 16'h0100, 16'hF000};
    lo_tab  = '{16'h4000, 16'h0000, 16'hFFFF, 16'h9000, 16'h0000, 16'h0F00};
    gap_tab = '{10'd2, 10'd0, 10'd1023, 10'd5, 10'd1, 10'd7};
    random_beats = 0;
    p = 0;
    while (random_beats < 1280) begin
      if (p < 6) begin
        program_regs(up_tab[p], lo_tab[p], gap_tab[p]);
      end else if (p == 6) begin
        program_regs(16'hC000, 16'h2000, 10'd600);
      end else begin
        lo = $urandom_range(0, 65535);
        if ($urandom_range(0, 4) == 0) up = $urandom_range(0, 65535);
        else up = $urandom_range(lo, 65535);
        gapv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 12);
        program_regs(THRESH_W'(up), THRESH_W'(lo), GAP_W'(gapv));
      end
      if (p == 6) begin
        len = $urandom_range(620, 640);
        random_run(len, 1'b1);
        random_beats += len;
      end else begin
        phase_beats = 0;
        phase_goal  = $urandom_range(40, 80);
        while (phase_beats < phase_goal) begin
          len = run_len();
          random_run(len, 1'b0);
          phase_beats += len;
        end
        random_beats += phase_beats;
      end
      settle();
      p++;
    end

    $display("Covered %0d frames in %0d runs under %0d register settings.",
             sb.n_frames, sb.n_runs, p + 2);
    $display("Checked %0d decisions: %0d by the gap rule, %0d new shots.",
             sb.n_results, sb.n_gap_rule, sb.n_shots);
    if (sb.n_errors == 0) begin
      $display("video_shot_boundary_classifier: match");
    end else begin
      $display("video_shot_boundary_classifier: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout with %0d decisions still waiting.", sb.outstanding());
    $display("video_shot_boundary_classifier: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
